// ----- hw/rtl/bdq_pkg.sv -----
// ----------------------------------------------------------------------------
// bdq_pkg
// shared types and constants for the bounded deque with index read
// ----------------------------------------------------------------------------
package bdq_pkg;

  localparam int CAPACITY = 256;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int COUNT_W  = $clog2(CAPACITY + 1);
  localparam int VALUE_W  = 32;
  localparam int INDEX_W  = 8;
  localparam int KIND_W   = 3;
  localparam int STATUS_W = 2;

  // request kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH_FRONT = 3'd0,
    KIND_PUSH_BACK  = 3'd1,
    KIND_POP_FRONT  = 3'd2,
    KIND_POP_BACK   = 3'd3,
    KIND_READ       = 3'd4
  } kind_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  // controller to datapath commands
  typedef struct packed {
    logic take;   // capture the incoming request
    logic exec;   // update pointers, write or read the store
    logic load;   // move the result into the output register
  } cmd_t;

endpackage

// ----- hw/rtl/bounded_deque_with_index_read.sv -----
// ----------------------------------------------------------------------------
// bounded_deque_with_index_read
// double-ended queue of 32-bit values in a 256-entry ring buffer
// ----------------------------------------------------------------------------
// requests arrive on the s_ stream: tuser carries the kind (push front, push
// back, pop front, pop back, read at index), tdata the value and the index.
// every request gives exactly one item on the m_ stream carrying the read
// value (zero unless a read succeeds), a status code and the element count
// after the request.
// a request is captured, then executed (pointer update, a write of the
// element store and a registered read of it), then moved into the output
// register once the output is free, which raises m_tvalid. a new request
// is accepted only after the previous result has moved into the output
// register, so requests do not overlap.
// the output register frees the input side: a new request is taken while a
// finished result still waits on m_; when the receiver stalls longer the
// block holds the next result and stops taking requests until it drains.
// reset empties the queue (head and count to zero) and drops any pending
// result; the store itself is not cleared, only slots inside the occupied
// span are ever returned as a read value.
// ----------------------------------------------------------------------------
module bounded_deque_with_index_read (
  input  logic        clk,
  input  logic        rst,
  // request stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // value [31:0], index [39:32]
  input  logic [2:0]  s_tuser,   // kind [2:0]
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata    // read_value [31:0], status [33:32], count [42:34]
);

  bdq_pkg::cmd_t                   cmd;
  logic [bdq_pkg::VALUE_W-1:0]     read_value;
  logic [bdq_pkg::STATUS_W-1:0]    status;
  logic [bdq_pkg::COUNT_W-1:0]     count;

  // sequencing and output valid
  bdq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  // store, pointers and result register
  bdq_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .in_kind    (s_tuser),
    .in_value   (s_tdata[31:0]),
    .in_index   (s_tdata[39:32]),
    .read_value (read_value),
    .status     (status),
    .count      (count)
  );

  // pack result fields, pad to whole bytes
  assign m_tdata = {5'b0, count, status, read_value};

endmodule

// ----- hw/rtl/bdq_ctrl.sv -----
// ----------------------------------------------------------------------------
// bdq_ctrl
// sequencer for request capture, execution and result hand-off
// ----------------------------------------------------------------------------
module bdq_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  output logic          m_tvalid,
  input  logic          m_tready,
  output bdq_pkg::cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_LOAD
  } state_t;

  state_t state;
  logic   out_free;

  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    cmd.take = (state == S_IDLE) && s_tvalid;
    cmd.exec = (state == S_EXEC);
    cmd.load = (state == S_LOAD) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          state <= S_LOAD;
        end
        S_LOAD: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- hw/rtl/bdq_datapath.sv -----
// ----------------------------------------------------------------------------
// bdq_datapath
// ring buffer store, head pointer, element count and result register
// ----------------------------------------------------------------------------
module bdq_datapath (
  input  logic                             clk,
  input  logic                             rst,
  input  bdq_pkg::cmd_t                    cmd,
  input  logic [bdq_pkg::KIND_W-1:0]       in_kind,
  input  logic [bdq_pkg::VALUE_W-1:0]      in_value,
  input  logic [bdq_pkg::INDEX_W-1:0]      in_index,
  output logic [bdq_pkg::VALUE_W-1:0]      read_value,
  output logic [bdq_pkg::STATUS_W-1:0]     status,
  output logic [bdq_pkg::COUNT_W-1:0]      count
);

  bdq_pkg::kind_t                  req_kind;
  logic [bdq_pkg::VALUE_W-1:0]     req_value;
  logic [bdq_pkg::INDEX_W-1:0]     req_index;

  logic [bdq_pkg::VALUE_W-1:0]     mem [bdq_pkg::CAPACITY];
  logic [bdq_pkg::VALUE_W-1:0]     rdata;

  logic [bdq_pkg::ADDR_W-1:0]      head;
  logic [bdq_pkg::ADDR_W-1:0]      head_next;
  logic [bdq_pkg::COUNT_W-1:0]     elem_count;
  logic [bdq_pkg::COUNT_W-1:0]     elem_count_next;
  bdq_pkg::status_t                st;
  bdq_pkg::status_t                st_next;
  logic                            read_ok;
  logic                            read_ok_next;

  logic                            full;
  logic                            empty;
  logic                            wr_en;
  logic [bdq_pkg::ADDR_W-1:0]      wr_addr;
  logic [bdq_pkg::ADDR_W-1:0]      rd_addr;

  assign full    = (elem_count == bdq_pkg::COUNT_W'(bdq_pkg::CAPACITY));
  assign empty   = (elem_count == '0);
  assign rd_addr = head + bdq_pkg::ADDR_W'(req_index);

  always_comb begin
    head_next       = head;
    elem_count_next = elem_count;
    st_next         = bdq_pkg::ST_OK;
    read_ok_next    = 1'b0;
    wr_en           = 1'b0;
    wr_addr         = head;
    case (req_kind)
      bdq_pkg::KIND_PUSH_FRONT: begin
        if (full) begin
          st_next = bdq_pkg::ST_FULL;
        end else begin
          head_next       = head - 1'b1;
          wr_addr         = head - 1'b1;
          wr_en           = 1'b1;
          elem_count_next = elem_count + 1'b1;
        end
      end
      bdq_pkg::KIND_PUSH_BACK: begin
        if (full) begin
          st_next = bdq_pkg::ST_FULL;
        end else begin
          wr_addr         = head + elem_count[bdq_pkg::ADDR_W-1:0];
          wr_en           = 1'b1;
          elem_count_next = elem_count + 1'b1;
        end
      end
      bdq_pkg::KIND_POP_FRONT: begin
        if (empty) begin
          st_next = bdq_pkg::ST_EMPTY;
        end else begin
          head_next       = head + 1'b1;
          elem_count_next = elem_count - 1'b1;
        end
      end
      bdq_pkg::KIND_POP_BACK: begin
        if (empty) begin
          st_next = bdq_pkg::ST_EMPTY;
        end else begin
          elem_count_next = elem_count - 1'b1;
        end
      end
      bdq_pkg::KIND_READ: begin
        if (empty) begin
          st_next = bdq_pkg::ST_EMPTY;
        end else if (bdq_pkg::COUNT_W'(req_index) >= elem_count) begin
          st_next = bdq_pkg::ST_RANGE;
        end else begin
          read_ok_next = 1'b1;
        end
      end
      default: begin
        st_next = bdq_pkg::ST_OK;
      end
    endcase
  end

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      req_kind  <= bdq_pkg::kind_t'(in_kind);
      req_value <= in_value;
      req_index <= in_index;
    end
  end

  // element store, registered read
  always_ff @(posedge clk) begin
    if (cmd.exec && wr_en) begin
      mem[wr_addr] <= req_value;
    end
    if (cmd.exec) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head       <= '0;
      elem_count <= '0;
    end else if (cmd.exec) begin
      head       <= head_next;
      elem_count <= elem_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      st      <= st_next;
      read_ok <= read_ok_next;
    end
    if (cmd.load) begin
      read_value <= read_ok ? rdata : '0;
      status     <= st;
      count      <= elem_count;
    end
  end

endmodule

// ----- dv/bounded_deque_with_index_read_tb.sv -----
// ----------------------------------------------------------------------------
// bounded_deque_with_index_read_tb
// self-checking stream testbench for the bounded deque with index read
// ----------------------------------------------------------------------------
// requests are driven on the s_ stream and every accepted request updates a
// mirror of the deque (ring slots, head, count) that predicts the one result
// it causes. results taken on the m_ stream are checked field by field
// against the oldest prediction. the run covers empty and full corners, the
// unused kind codes, a full fill and drain sweep, mixed random traffic under
// several idling patterns and one long receiver hold-off that backs the
// block up into its input.
// ----------------------------------------------------------------------------
module bounded_deque_with_index_read_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // kind codes the block treats as no operation
  localparam logic [bdq_pkg::KIND_W-1:0] KIND_UNUSED_FIRST = 3'd5;
  localparam logic [bdq_pkg::KIND_W-1:0] KIND_UNUSED_LAST  = 3'd7;

  localparam int HOLD_CYCLES    = 200;   // long receiver hold-off
  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no item moving
  localparam int DRAIN_CYCLES   = 10;    // settle time after the last result

  // one predicted result
  typedef struct {
    logic [bdq_pkg::VALUE_W-1:0] read_value;
    bdq_pkg::status_t            status;
    logic [bdq_pkg::COUNT_W-1:0] count;
  } deque_result_t;

  // mirror of the deque plus the results still owed by the block
  class deque_scoreboard;
    logic [bdq_pkg::VALUE_W-1:0] slots [bdq_pkg::CAPACITY];
    logic [bdq_pkg::ADDR_W-1:0]  head;
    logic [bdq_pkg::COUNT_W-1:0] count;
    deque_result_t               pending_results [$];
    int                          errors;

    function new();
      head   = '0;
      count  = '0;
      errors = 0;
    endfunction

    // apply an accepted request to the mirror and queue its result
    function void note_request(logic [bdq_pkg::KIND_W-1:0] kind,
                               logic [bdq_pkg::VALUE_W-1:0] value,
                               logic [bdq_pkg::INDEX_W-1:0] index);
      deque_result_t res;
      res.read_value = '0;
      res.status     = bdq_pkg::ST_OK;
      case (kind)
        bdq_pkg::KIND_PUSH_FRONT: begin
          if (count >= bdq_pkg::CAPACITY) begin
            res.status = bdq_pkg::ST_FULL;
          end else begin
            head        = head - 1'b1;
            slots[head] = value;
            count++;
          end
        end
        bdq_pkg::KIND_PUSH_BACK: begin
          if (count >= bdq_pkg::CAPACITY) begin
            res.status = bdq_pkg::ST_FULL;
          end else begin
            slots[bdq_pkg::ADDR_W'(head + count)] = value;
            count++;
          end
        end
        bdq_pkg::KIND_POP_FRONT: begin
          if (count == 0) begin
            res.status = bdq_pkg::ST_EMPTY;
          end else begin
            head = head + 1'b1;
            count--;
          end
        end
        bdq_pkg::KIND_POP_BACK: begin
          if (count == 0) res.status = bdq_pkg::ST_EMPTY;
          else count--;
        end
        bdq_pkg::KIND_READ: begin
          if (count == 0) res.status = bdq_pkg::ST_EMPTY;
          else if (index >= count) res.status = bdq_pkg::ST_RANGE;
          else res.read_value = slots[bdq_pkg::ADDR_W'(head + index)];
        end
        default: ;  // unused codes change nothing
      endcase
      res.count = count;
      pending_results.insert(pending_results.size(), res);
    endfunction

    task report_mismatch(string what, longint unsigned got, longint unsigned want);
      $display("[%0t] mismatch on %s: got 0x%0h expected 0x%0h", $realtime, what, got,
               want);
      errors++;
    endtask

    // compare one accepted result with the oldest prediction
    task check_result(logic [47:0] data);
      deque_result_t want;
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending", data, 0);
      end else begin
        want = pending_results[0];
        pending_results.delete(0);
        if (data[31:0] !== want.read_value)
          report_mismatch("read_value", data[31:0], want.read_value);
        if (data[33:32] !== want.status)
          report_mismatch("status", data[33:32], want.status);
        if (data[42:34] !== want.count)
          report_mismatch("count", data[42:34], want.count);
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;   // value [31:0], index [39:32]
  logic [2:0]  s_tuser = '0;   // kind [2:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;        // read_value [31:0], status [33:32], count [42:34]

  deque_scoreboard mirror = new();

  int   tx_idle_pct  = 0;   // chance per cycle that the sender holds back
  int   rx_stall_pct = 0;   // chance per cycle that the receiver stalls
  logic rx_hold = 1'b0;     // forces the receiver off during the hold-off
  int   quiet_cycles = 0;

  always #10 clk = ~clk;

  bounded_deque_with_index_read u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // receiver: random stalls, or held off completely
  always @(posedge clk) begin
    m_tready <= rx_hold ? 1'b0 : ($urandom_range(99) >= rx_stall_pct);
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) mirror.check_result(m_tdata);
  end

  // watchdog: nothing moving on either side for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("bounded_deque_with_index_read_tb: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // offer one item, hold it until taken, then record it in the mirror.
  // valid stays high on return so back-to-back items need no extra edge
  task automatic send_item(logic [bdq_pkg::KIND_W-1:0] kind,
                           logic [bdq_pkg::VALUE_W-1:0] value,
                           logic [bdq_pkg::INDEX_W-1:0] index);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {index, value};
    s_tuser  <= kind;
    do @(posedge clk); while (!s_tready);
    mirror.note_request(kind, value, index);
  endtask

  // mostly random words, now and then all zeros or all ones
  function automatic logic [bdq_pkg::VALUE_W-1:0] pick_value();
    case ($urandom_range(15))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // one random request; push_pct and pop_pct steer the fill level,
  // reads take most of the rest and a few use the unused codes
  task automatic send_random(int push_pct, int pop_pct);
    int                          r;
    logic [bdq_pkg::KIND_W-1:0]  kind;
    logic [bdq_pkg::INDEX_W-1:0] index;
    r     = $urandom_range(99);
    index = bdq_pkg::INDEX_W'($urandom_range(255));
    if (r < push_pct) begin
      kind = $urandom_range(1) ? bdq_pkg::KIND_PUSH_BACK : bdq_pkg::KIND_PUSH_FRONT;
    end else if (r < push_pct + pop_pct) begin
      kind = $urandom_range(1) ? bdq_pkg::KIND_POP_BACK : bdq_pkg::KIND_POP_FRONT;
    end else if (r < 98) begin
      kind = bdq_pkg::KIND_READ;
      // mostly inside the occupied span, sometimes anywhere
      if (mirror.count != 0 && $urandom_range(9) < 8)
        index = bdq_pkg::INDEX_W'($urandom_range(mirror.count - 1));
    end else begin
      kind = bdq_pkg::KIND_W'($urandom_range(KIND_UNUSED_LAST, KIND_UNUSED_FIRST));
    end
    send_item(kind, pick_value(), index);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // -- directed corners, no idling --
    // pops and reads on an empty queue
    send_item(bdq_pkg::KIND_POP_FRONT, '1, '0);
    send_item(bdq_pkg::KIND_POP_BACK, '0, '1);
    send_item(bdq_pkg::KIND_READ, $urandom, 8'd0);
    send_item(bdq_pkg::KIND_READ, $urandom, 8'd255);
    // unused kind codes do nothing
    for (int k = KIND_UNUSED_FIRST; k <= KIND_UNUSED_LAST; k++)
      send_item(bdq_pkg::KIND_W'(k), $urandom,
                bdq_pkg::INDEX_W'($urandom_range(255)));
    // pushes at both ends with extreme and alternating values
    send_item(bdq_pkg::KIND_PUSH_BACK, '1, '0);
    send_item(bdq_pkg::KIND_PUSH_FRONT, '0, '1);
    send_item(bdq_pkg::KIND_PUSH_BACK, 32'h5A5A_A5A5, 8'h55);
    send_item(bdq_pkg::KIND_PUSH_FRONT, 32'hA5A5_5A5A, 8'hAA);
    // reads at the front, the last element, one past it and far past it
    send_item(bdq_pkg::KIND_READ, '0, 8'd0);
    send_item(bdq_pkg::KIND_READ, '0, 8'd3);
    send_item(bdq_pkg::KIND_READ, '1, 8'd4);
    send_item(bdq_pkg::KIND_READ, '0, 8'd255);
    // drain from both ends with reads in between, then pop once more on empty
    send_item(bdq_pkg::KIND_POP_FRONT, $urandom, '0);
    send_item(bdq_pkg::KIND_POP_BACK, $urandom, '0);
    send_item(bdq_pkg::KIND_READ, '0, 8'd0);
    send_item(bdq_pkg::KIND_READ, '0, 8'd1);
    send_item(bdq_pkg::KIND_POP_BACK, $urandom, '0);
    send_item(bdq_pkg::KIND_POP_FRONT, $urandom, '0);
    send_item(bdq_pkg::KIND_POP_FRONT, $urandom, '0);

    // -- mixed random traffic, no idling --
    repeat (150) send_random(40, 35);

    // -- long receiver hold-off: the block backs up and stalls its input --
    fork
      begin
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
      end
      repeat (40) send_random(40, 35);
    join

    // -- fill to capacity, then push into the full queue, idle sender --
    tx_idle_pct  = 68;
    rx_stall_pct = 0;
    while (mirror.count < bdq_pkg::CAPACITY) send_random(88, 0);
    repeat (3) send_random(100, 0);
    send_item(bdq_pkg::KIND_READ, '0, 8'd255);

    // -- drain to empty, then pop the empty queue, stalling receiver --
    tx_idle_pct  = 0;
    rx_stall_pct = 68;
    while (mirror.count != 0) send_random(0, 88);
    repeat (3) send_random(0, 100);

    // -- mixed random traffic, both sides idling --
    tx_idle_pct  = 24;
    rx_stall_pct = 24;
    repeat (100) send_random(40, 35);

    s_tvalid     <= 1'b0;
    rx_stall_pct = 0;
    while (mirror.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mirror.errors == 0 && mirror.pending_results.size() == 0) begin
      $display("bounded_deque_with_index_read_tb: PASS");
    end else begin
      $display("bounded_deque_with_index_read_tb: FAIL");
    end
    $finish;
  end

endmodule
